// ===== hw/rtl/i2p_pkg.sv =====
// shared types and constants for the ieee single to pdp-11 f-format converter
// no dependencies
package i2p_pkg;

    localparam int FracBits     = 23;
    localparam int ExpBits      = 8;
    localparam int LzBits       = 5;
    localparam int ExBits       = 10;
    localparam int Rebias       = 2;
    localparam int PdpBias      = 128;
    localparam int PdpExpMax    = 2 * PdpBias - 1;
    localparam int InDataBits   = 32;
    localparam int OutDataBits  = 32;
    localparam int OutUserBits  = 4;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_ZERO      = 3'd1,
        ST_INFNAN    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

endpackage

// ===== hw/rtl/ieee_single_to_pdp11_float.sv =====
// top level of the ieee single to pdp-11 f-format converter
// depends on i2p_pkg and i2p_lzc
//
// Takes one IEEE 754 single word per item and gives the PDP-11 F-format
// double word with an exactness flag and a status code. The converter is a
// three-stage pipeline (decode with leading-zero count, normalise and rebias,
// range check and pack into the output register); it accepts one word per
// clock and each word taken passes through the decode, normalise and output
// registers in turn. The whole pipeline holds while a finished result waits on
// i_m_tready, so throughput is one item per cycle whenever the output side
// keeps up.
module ieee_single_to_pdp11_float (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [i2p_pkg::InDataBits-1:0]    i_s_tdata,   // [31:0] ieee_word
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [i2p_pkg::OutDataBits-1:0]   o_m_tdata,   // [15:0] high_word, [31:16] low_word
    output logic [i2p_pkg::OutUserBits-1:0]   o_m_tuser    // [0] exact_ok, [3:1] status
);

    localparam int Fb = i2p_pkg::FracBits;
    localparam int Eb = i2p_pkg::ExpBits;
    localparam int Xb = i2p_pkg::ExBits;

    logic w_en;
    logic [i2p_pkg::LzBits-1:0] w_lz;

    // stage 1: decode
    logic              r_v1;
    logic              r_s1_sign;
    logic [Eb-1:0]     r_s1_exp;
    logic [Fb-1:0]     r_s1_frac;
    logic [i2p_pkg::LzBits-1:0] r_s1_lz;
    i2p_pkg::t_status  r_s1_cls;
    i2p_pkg::t_status  n_s1_cls;

    // stage 2: normalise and rebias
    logic              r_v2;
    logic              r_s2_sign;
    logic signed [Xb-1:0] r_s2_ex;
    logic [Fb-1:0]     r_s2_frac;
    i2p_pkg::t_status  r_s2_cls;
    logic signed [Xb-1:0] n_s2_ex;
    logic [Fb-1:0]     n_s2_frac;
    logic [Fb-1:0]     w_shifted;

    // stage 3: output register
    logic              r_o_tvalid;
    logic [15:0]       r_o_high;
    logic [15:0]       r_o_low;
    logic              r_o_ok;
    i2p_pkg::t_status  r_o_status;
    logic [15:0]       n_o_high;
    logic [15:0]       n_o_low;
    logic              n_o_ok;
    i2p_pkg::t_status  n_o_status;

    assign w_en       = !r_o_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    i2p_lzc u_lzc (
        .i_frac  (i_s_tdata[Fb-1:0]),
        .o_count (w_lz)
    );

    always_comb begin
        if (i_s_tdata[30:0] == 31'd0) begin
            n_s1_cls = i2p_pkg::ST_ZERO;
        end else if (i_s_tdata[30:23] == {Eb{1'b1}}) begin
            n_s1_cls = i2p_pkg::ST_INFNAN;
        end else begin
            n_s1_cls = i2p_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sign <= i_s_tdata[31];
            r_s1_exp  <= i_s_tdata[30:23];
            r_s1_frac <= i_s_tdata[Fb-1:0];
            r_s1_lz   <= w_lz;
            r_s1_cls  <= n_s1_cls;
        end
    end

    // leading one lands on the hidden bit and drops out
    assign w_shifted = Fb'({r_s1_frac, 1'b0} << r_s1_lz);

    always_comb begin
        if (r_s1_exp == '0) begin
            n_s2_ex   = Xb'(signed'(i2p_pkg::Rebias))
                        - signed'({{(Xb-i2p_pkg::LzBits){1'b0}}, r_s1_lz});
            n_s2_frac = w_shifted;
        end else begin
            n_s2_ex   = signed'({{(Xb-Eb){1'b0}}, r_s1_exp}) + Xb'(signed'(i2p_pkg::Rebias));
            n_s2_frac = r_s1_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sign <= r_s1_sign;
            r_s2_ex   <= n_s2_ex;
            r_s2_frac <= n_s2_frac;
            r_s2_cls  <= r_s1_cls;
        end
    end

    always_comb begin
        n_o_high   = 16'd0;
        n_o_low    = 16'd0;
        n_o_ok     = 1'b0;
        n_o_status = r_s2_cls;
        case (r_s2_cls)
            i2p_pkg::ST_ZERO: begin
                n_o_ok = 1'b1;
            end
            i2p_pkg::ST_INFNAN: begin
                n_o_high = {r_s2_sign, {Eb{1'b1}}, 7'd0};
            end
            default: begin
                if (r_s2_ex <= Xb'(signed'(0))) begin
                    n_o_status = i2p_pkg::ST_UNDERFLOW;
                end else if (r_s2_ex > Xb'(signed'(i2p_pkg::PdpExpMax))) begin
                    n_o_status = i2p_pkg::ST_OVERFLOW;
                    n_o_high   = {r_s2_sign, 15'h7FFF};
                    n_o_low    = 16'hFFFF;
                end else begin
                    n_o_status = i2p_pkg::ST_NORMAL;
                    n_o_ok     = 1'b1;
                    n_o_high   = {r_s2_sign, r_s2_ex[Eb-1:0], r_s2_frac[Fb-1:16]};
                    n_o_low    = r_s2_frac[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_tvalid <= 1'b0;
        end else if (w_en) begin
            r_o_tvalid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_high   <= n_o_high;
            r_o_low    <= n_o_low;
            r_o_ok     <= n_o_ok;
            r_o_status <= n_o_status;
        end
    end

    assign o_m_tvalid = r_o_tvalid;
    assign o_m_tdata  = {r_o_low, r_o_high};
    assign o_m_tuser  = {r_o_status, r_o_ok};

    // exactness flag agrees with the status code
    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] ==
            ((r_o_status == i2p_pkg::ST_NORMAL) || (r_o_status == i2p_pkg::ST_ZERO))))
        else $error("exact_ok inconsistent with status");

    // zero and underflow results carry all-zero words
    a_zero_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((r_o_status == i2p_pkg::ST_ZERO) ||
                        (r_o_status == i2p_pkg::ST_UNDERFLOW))) |-> (o_m_tdata == 32'd0))
        else $error("zero or underflow result with non-zero words");

    // an item inside the pipeline survives a stall
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && (r_v1 || r_v2)) |=> (r_v1 == $past(r_v1)) && (r_v2 == $past(r_v2)))
        else $error("pipeline item lost during stall");

    // a normal result never carries a zero exponent
    a_normal_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_o_status == i2p_pkg::ST_NORMAL)) |-> (r_o_high[14:7] != 8'd0))
        else $error("normal result with zero exponent");

endmodule

// ===== hw/rtl/i2p_lzc.sv =====
// leading-zero counter over the single-precision fraction field
// depends on i2p_pkg
module i2p_lzc (
    input  logic [i2p_pkg::FracBits-1:0] i_frac,
    output logic [i2p_pkg::LzBits-1:0]   o_count
);

    always_comb begin
        o_count = i2p_pkg::LzBits'(i2p_pkg::FracBits);
        for (int i = 0; i < i2p_pkg::FracBits; i++) begin
            if (i_frac[i]) begin
                o_count = i2p_pkg::LzBits'(i2p_pkg::FracBits - 1 - i);
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the ieee single to pdp-11 f-format converter
// drives ieee words through the input stream and checks every result item
// depends on i2p_pkg and ieee_single_to_pdp11_float
module testbench;

    localparam int PdpRebias      = 2;
    localparam int PdpExpLimit    = 2 * 128 - 1;
    localparam int StallLimit     = 5000;
    localparam int DrainCycles    = 10;
    localparam int HoldAtResult   = 850;
    localparam int HoldCycles     = 150;
    localparam int RandomPerPhase = 343;

    typedef struct packed {
        logic [15:0]      high_word;
        logic [15:0]      low_word;
        logic             exact_ok;
        i2p_pkg::t_status status;
    } t_pdp_result;

    typedef enum int {
        WC_ANY, WC_DENORM, WC_DENORM_TOP, WC_INFNAN, WC_EXP_EDGE, WC_ZERO
    } t_word_class;

    localparam logic [7:0] ExpEdges [4] = '{8'd1, 8'd2, 8'd253, 8'd254};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    logic [31:0] pending_words [$];
    t_pdp_result expected_results [$];
    int          send_idle_pct = 6;
    int          recv_idle_pct = 75;
    int          results_seen = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          err_count = 0;
    int          quiet_cycles = 0;

    ieee_single_to_pdp11_float dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    function automatic t_pdp_result pdp_convert(input logic [31:0] word);
        logic [23:0] mant;
        logic [31:0] dw;
        int          ex;
        t_pdp_result r;
        r.exact_ok = 1'b0;
        if (word[30:0] == '0) begin
            dw = '0;
            r.exact_ok = 1'b1;
            r.status = i2p_pkg::ST_ZERO;
        end else if (word[30:23] == 8'hFF) begin
            dw = {word[31], 8'hFF, 23'h0};
            r.status = i2p_pkg::ST_INFNAN;
        end else begin
            ex = int'(word[30:23]);
            mant = {1'b0, word[22:0]};
            // denormal: shift the leading one up to the hidden bit, then drop it
            if (ex == 0) begin
                mant = mant << 1;
                for (int i = 0; i < 23 && !mant[23]; i++) begin
                    mant = mant << 1;
                    ex = ex - 1;
                end
            end
            ex = ex + PdpRebias;
            if (ex <= 0) begin
                dw = '0;
                r.status = i2p_pkg::ST_UNDERFLOW;
            end else if (ex > PdpExpLimit) begin
                dw = {word[31], 31'h7FFF_FFFF};
                r.status = i2p_pkg::ST_OVERFLOW;
            end else begin
                dw = {word[31], ex[7:0], mant[22:0]};
                r.exact_ok = 1'b1;
                r.status = i2p_pkg::ST_NORMAL;
            end
        end
        r.high_word = dw[31:16];
        r.low_word = dw[15:0];
        return r;
    endfunction

    function automatic logic [31:0] random_ieee_word();
        logic [31:0] w;
        t_word_class wc;
        w = $urandom;
        wc = ($urandom_range(2) == 0) ? t_word_class'($urandom_range(WC_ZERO)) : WC_ANY;
        case (wc)
            WC_DENORM: begin
                w[30:23] = '0;
                w[22:0] = w[22:0] >> $urandom_range(22);
            end
            WC_DENORM_TOP: begin
                w[30:23] = '0;
                w[22:0] = w[22:0] >> $urandom_range(2);
            end
            WC_INFNAN: w[30:23] = 8'hFF;
            WC_EXP_EDGE: w[30:23] = ExpEdges[$urandom_range(3)];
            WC_ZERO: w[30:0] = '0;
            default: ;
        endcase
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(pdp_convert(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_words.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_pdp_result exp_r;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    err_count <= err_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[15:0] !== exp_r.high_word ||
                        m_tdata[31:16] !== exp_r.low_word ||
                        m_tuser[0] !== exp_r.exact_ok ||
                        m_tuser[3:1] !== exp_r.status)
                        err_count <= err_count + 1;
                    if (m_tdata[15:0] !== exp_r.high_word)
                        $error("high_word: expected %h, got %h",
                               exp_r.high_word, m_tdata[15:0]);
                    if (m_tdata[31:16] !== exp_r.low_word)
                        $error("low_word: expected %h, got %h",
                               exp_r.low_word, m_tdata[31:16]);
                    if (m_tuser[0] !== exp_r.exact_ok)
                        $error("exact_ok: expected %b, got %b",
                               exp_r.exact_ok, m_tuser[0]);
                    if (m_tuser[3:1] !== exp_r.status)
                        $error("status: expected %0d, got %0d",
                               exp_r.status, m_tuser[3:1]);
                end
            end
            // long hold-off so the pipeline fills and stalls its input
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (results_seen >= HoldAtResult && !hold_done) begin
                m_tready <= 1'b0;
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // zeros, inf and nan, denormal edges, exponent edges, bit patterns
        pending_words = '{
            32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h801F_FFFF,
            32'h0020_0000, 32'h8040_0000, 32'h007F_FFFF, 32'h0060_0001,
            32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7EFF_FFFF,
            32'hFEFF_FFFF, 32'h7F00_0000, 32'hFF7F_FFFF, 32'h5555_5555,
            32'hAAAA_AAAA
        };
        repeat (RandomPerPhase) pending_words.push_back(random_ieee_word());
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 6;
        repeat (RandomPerPhase) pending_words.push_back(random_ieee_word());
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RandomPerPhase + 1) pending_words.push_back(random_ieee_word());
        wait_drained();

        repeat (DrainCycles) @(posedge clk);
        if (expected_results.size() != 0)
            $error("%0d expected result items never arrived", expected_results.size());
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
